/* sv/tfd_pkg.sv */
// Shared types and constants for the thermocouple frame decoder.
package tfd_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W = 2;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TEMP_W = 16;
    localparam int FLAG_W = 4;
    localparam int SUMMARY_W = 8;

    localparam logic [TEMP_W-1:0] SENTINEL_RESET = 16'h8000;

    // fault flag codes
    localparam logic [FLAG_W-1:0] FLT_NONE  = 4'h0;
    localparam logic [FLAG_W-1:0] FLT_NOANS = 4'h8;

    // register map
    localparam logic [0:0] REG_INVALID_SENTINEL = 1'b0;

    typedef struct packed {
        logic [TEMP_W-1:0] hot;
        logic [TEMP_W-1:0] cold;
        logic [FLAG_W-1:0] flags;
        logic              valid;
    } rec_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] ch;
        rec_t            rec;
    } store_wr_t;

endpackage

/* sv/tfd_decode.sv */
// Frame decode: fault bits, temperature fields and the new channel record.
module tfd_decode (
    input  logic [tfd_pkg::CH_W-1:0]   channel,
    input  logic [31:0]                frame,
    input  logic                       bus_error,
    input  logic [tfd_pkg::TEMP_W-1:0] sentinel,
    input  logic [tfd_pkg::TEMP_W-1:0] stored_cold,
    output logic                       in_range,
    output tfd_pkg::rec_t              rec
);

    logic        no_answer;
    logic        hot_bad;
    logic [13:0] hot_raw;
    logic [13:0] hot_adj;
    logic [11:0] cold_raw;
    logic [11:0] cold_adj;
    logic [tfd_pkg::TEMP_W-1:0] hot_deg;
    logic [tfd_pkg::TEMP_W-1:0] cold_deg;

    assign in_range = ({1'b0, channel} < (tfd_pkg::CH_W + 1)'(tfd_pkg::CHANNELS));
    assign no_answer = (frame == 32'h0000_0000) || (frame == 32'hFFFF_FFFF);
    assign hot_bad = frame[16] || (frame[2:0] != 3'b000);

    // divide toward zero: bias negatives before the arithmetic shift
    assign hot_raw  = frame[31:18];
    assign hot_adj  = hot_raw + (hot_raw[13] ? 14'd3 : 14'd0);
    assign hot_deg  = {{4{hot_adj[13]}}, hot_adj[13:2]};
    assign cold_raw = frame[15:4];
    assign cold_adj = cold_raw + (cold_raw[11] ? 12'd15 : 12'd0);
    assign cold_deg = {{8{cold_adj[11]}}, cold_adj[11:4]};

    always_comb
    begin
        rec.hot   = sentinel;
        rec.cold  = sentinel;
        rec.flags = tfd_pkg::FLT_NOANS;
        rec.valid = 1'b0;
        priority if (bus_error)
        begin
            rec.cold = stored_cold;
        end
        else if (no_answer)
        begin
            rec.cold = sentinel;
        end
        else
        begin
            rec.cold  = cold_deg;
            rec.flags = {1'b0, frame[2:0]};
            if (!hot_bad)
            begin
                rec.hot   = hot_deg;
                rec.valid = 1'b1;
            end
        end
    end

endmodule

/* sv/tfd_store.sv */
// Per-channel record registers, read port and fault summary.
module tfd_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tfd_pkg::store_wr_t            wr,
    input  logic [tfd_pkg::CH_W-1:0]      rd_ch,
    output tfd_pkg::rec_t                 rd_rec,
    output logic [tfd_pkg::SUMMARY_W-1:0] summary_next
);

    tfd_pkg::rec_t rec_reg [tfd_pkg::CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < tfd_pkg::CHANNELS; c++)
            begin
                rec_reg[c].hot   <= tfd_pkg::SENTINEL_RESET;
                rec_reg[c].cold  <= tfd_pkg::SENTINEL_RESET;
                rec_reg[c].flags <= tfd_pkg::FLT_NOANS;
                rec_reg[c].valid <= 1'b0;
            end
        end
        else if (wr.en)
        begin
            rec_reg[wr.ch[tfd_pkg::CH_IDX_W-1:0]] <= wr.rec;
        end
    end

    assign rd_rec = rec_reg[rd_ch[tfd_pkg::CH_IDX_W-1:0]];

    // summary as it stands after this cycle's write
    always_comb
    begin
        logic [tfd_pkg::FLAG_W-1:0] f;
        summary_next = '0;
        for (int c = 0; c < tfd_pkg::CHANNELS; c++)
        begin
            f = rec_reg[c].flags;
            if (wr.en && (wr.ch[tfd_pkg::CH_IDX_W-1:0] == tfd_pkg::CH_IDX_W'(c)))
            begin
                f = wr.rec.flags;
            end
            summary_next[2*c]     = (f != tfd_pkg::FLT_NONE);
            summary_next[2*c + 1] = f[3];
        end
    end

endmodule

/* sv/thermocouple_frame_decoder.sv */
// Thermocouple frame decoder top level: input stage, decode, record store, result register.
// One converter frame per transfer on the input channel; each transfer yields exactly one
// result, loaded into the result register at the edge where it leaves the input register, so
// with out_ready held high a new one is taken every cycle. The input register and the result
// register form a two-stage pipeline; the per-channel record is updated at the same edge that
// loads the result, so back-to-back frames to one channel see each other's updates. The
// invalid sentinel lives at APB address 0 and should be written only while no frames are in
// flight; records already holding the old sentinel keep it.
module thermocouple_frame_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // frame input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tfd_pkg::CH_W-1:0]      channel,
    input  logic [31:0]                   frame,
    input  logic                          bus_error,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tfd_pkg::CH_W-1:0]      channel_out,
    output logic signed [15:0]            hot_temp,
    output logic signed [15:0]            cold_temp,
    output logic [tfd_pkg::FLAG_W-1:0]    fault_flags,
    output logic                          reading_valid,
    output logic [tfd_pkg::SUMMARY_W-1:0] fault_summary
);

    logic [tfd_pkg::TEMP_W-1:0]    sentinel_reg;
    logic                          s1_valid_reg;
    logic [tfd_pkg::CH_W-1:0]      s1_channel_reg;
    logic [31:0]                   s1_frame_reg;
    logic                          s1_berr_reg;
    logic                          out_valid_reg;
    logic [tfd_pkg::CH_W-1:0]      ch_out_reg;
    tfd_pkg::rec_t                 rec_out_reg;
    logic [tfd_pkg::SUMMARY_W-1:0] summary_reg;

    logic                          advance;
    logic                          fire;
    logic                          cfg_wr;
    logic                          in_range;
    logic [tfd_pkg::CH_W-1:0]      rd_ch;
    tfd_pkg::rec_t                 rd_rec;
    tfd_pkg::rec_t                 dec_rec;
    tfd_pkg::store_wr_t            wr;
    logic [tfd_pkg::SUMMARY_W-1:0] summary_next;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tfd_pkg::REG_INVALID_SENTINEL);
    assign prdata = (paddr[2] == tfd_pkg::REG_INVALID_SENTINEL)
                  ? {{16{sentinel_reg[15]}}, sentinel_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sentinel_reg <= tfd_pkg::SENTINEL_RESET;
        end
        else if (cfg_wr)
        begin
            sentinel_reg <= pwdata[15:0];
        end
    end

    // pipeline control
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign fire     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_channel_reg <= channel;
            s1_frame_reg   <= frame;
            s1_berr_reg    <= bus_error;
        end
        if (fire)
        begin
            ch_out_reg  <= in_range ? s1_channel_reg : '0;
            rec_out_reg <= in_range ? dec_rec : rd_rec;
            summary_reg <= summary_next;
        end
    end

    assign rd_ch = in_range ? s1_channel_reg : '0;

    tfd_decode u_decode (
        .channel     (s1_channel_reg),
        .frame       (s1_frame_reg),
        .bus_error   (s1_berr_reg),
        .sentinel    (sentinel_reg),
        .stored_cold (rd_rec.cold),
        .in_range    (in_range),
        .rec         (dec_rec)
    );

    always_comb
    begin
        wr.en  = fire && in_range;
        wr.ch  = s1_channel_reg;
        wr.rec = dec_rec;
    end

    tfd_store u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .rd_ch        (rd_ch),
        .rd_rec       (rd_rec),
        .summary_next (summary_next)
    );

    assign out_valid     = out_valid_reg;
    assign channel_out   = ch_out_reg;
    assign hot_temp      = rec_out_reg.hot;
    assign cold_temp     = rec_out_reg.cold;
    assign fault_flags   = rec_out_reg.flags;
    assign reading_valid = rec_out_reg.valid;
    assign fault_summary = summary_reg;

    a_valid_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reading_valid |-> fault_flags == tfd_pkg::FLT_NONE)
        else $error("valid reading reported with fault flags");

    a_noans_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_flags[3] |-> fault_flags[2:0] == 3'b000)
        else $error("no-answer flag combined with detail faults");

    a_summary_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fault_summary[{channel_out, 1'b0}] == (fault_flags != tfd_pkg::FLT_NONE))
                   && (fault_summary[{channel_out, 1'b1}] == fault_flags[3]))
        else $error("fault summary disagrees with reported record");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("decoded frame produced no result");

endmodule
